[hdl/point_to_plane_distance_macros.svh]
`ifndef POINT_TO_PLANE_DISTANCE_MACROS_SVH
`define POINT_TO_PLANE_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define P2P_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define P2P_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define P2P_ASSERT(lbl, clk, rst_n, prop, msg)
`define P2P_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/p2pd_pkg.sv]
package p2pd_pkg;
  localparam int unsigned CoefBits = 32;
  localparam int unsigned OffsBits = 48;
  localparam int unsigned CfgAddrBits = 2;
  localparam int unsigned SumBits = 66;
  localparam int unsigned NormBits = 66;

  typedef enum logic [CfgAddrBits-1:0] {
    RegCoefX   = 2'd0,
    RegCoefY   = 2'd1,
    RegCoefZ   = 2'd2,
    RegCoefOff = 2'd3
  } cfg_reg_e;
endpackage

[hdl/p2pd_front.sv]
module p2pd_front import p2pd_pkg::*; #(
  parameter int unsigned CoordBits = 16,
  parameter int unsigned MagBits = 49
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CoefBits-1:0]  coef_x_i,
  input  logic signed [CoefBits-1:0]  coef_y_i,
  input  logic signed [CoefBits-1:0]  coef_z_i,
  input  logic signed [OffsBits-1:0]  coef_off_i,
  input  logic signed [CoordBits-1:0] px_i,
  input  logic signed [CoordBits-1:0] py_i,
  input  logic signed [CoordBits-1:0] pz_i,
  output logic [MagBits-1:0]          num_o,
  output logic [NormBits-1:0]         norm_o
);
  localparam int unsigned PB = CoefBits + CoordBits;
  logic signed [PB-1:0] px_q, py_q, pz_q;
  logic signed [SumBits-1:0] sum;
  logic [CoefBits-1:0] ax, ay, az;
  logic [2*CoefBits-1:0] ax2, ay2, az2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= coef_x_i * px_i;
      py_q <= coef_y_i * py_i;
      pz_q <= coef_z_i * pz_i;
    end
  end

  assign sum = SumBits'(px_q) + SumBits'(py_q) + SumBits'(pz_q) + SumBits'(coef_off_i);
  assign ax = $unsigned(coef_x_i[CoefBits-1] ? -coef_x_i : coef_x_i);
  assign ay = $unsigned(coef_y_i[CoefBits-1] ? -coef_y_i : coef_y_i);
  assign az = $unsigned(coef_z_i[CoefBits-1] ? -coef_z_i : coef_z_i);
  assign ax2 = ax * ax;
  assign ay2 = ay * ay;
  assign az2 = az * az;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= sum[SumBits-1] ? MagBits'(-sum) : MagBits'(sum);
      norm_o <= NormBits'(ax2) + NormBits'(ay2) + NormBits'(az2);
    end
  end
endmodule

[hdl/p2pd_cell.sv]
module p2pd_cell import p2pd_pkg::*; #(
  parameter int unsigned DistBits = 16,
  parameter int unsigned ResBits = 101,
  parameter int unsigned AccBits = 83,
  parameter int unsigned BitPos = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [ResBits-1:0]  r_i,
  input  logic [AccBits-1:0]  t_i,
  input  logic [NormBits-1:0] s_i,
  input  logic [DistBits:0]   q_i,
  input  logic                dgn_i,
  output logic [ResBits-1:0]  r_o,
  output logic [AccBits-1:0]  t_o,
  output logic [NormBits-1:0] s_o,
  output logic [DistBits:0]   q_o,
  output logic                dgn_o
);
  logic [ResBits-1:0] trial;
  logic take;

  // The residual holds m*m - q*q*s and the accumulator holds q*s.
  assign trial = (ResBits'(t_i) << (BitPos + 1)) + (ResBits'(s_i) << (2 * BitPos));
  assign take = (trial <= r_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o   <= take ? r_i - trial : r_i;
      t_o   <= take ? t_i + (AccBits'(s_i) << BitPos) : t_i;
      s_o   <= s_i;
      q_o   <= take ? (q_i | ((DistBits+1)'(1) << BitPos)) : q_i;
      dgn_o <= dgn_i;
    end
  end
endmodule

[hdl/point_to_plane_distance.sv]
// Throughput: one item per cycle while the output is not stalled, through two front stages,
// two squaring stages and a row of DIST_BITS + 1 cells that settle one quotient bit each,
// the first one flagging saturation.
// A stalled output freezes the whole pipeline; the input is ready whenever the output is.
// Reset clears all valid bits and coefficient registers to zero.
module point_to_plane_distance import p2pd_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DIST_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // distance, saturated, degenerate
  output logic [((DIST_BITS+2+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [OffsBits-1:0] cfg_wdata_i
);
`include "point_to_plane_distance_macros.svh"
  localparam int unsigned MB = (COORD_BITS + CoefBits + 1 > OffsBits + 1) ?
    COORD_BITS + CoefBits + 1 : OffsBits + 1;
  localparam int unsigned HB = (MB + 1) / 2;
  localparam int unsigned RW = (2 * MB > NormBits + 2 * DIST_BITS + 3) ?
    2 * MB : NormBits + 2 * DIST_BITS + 3;
  localparam int unsigned TW = NormBits + DIST_BITS + 1;
  localparam int unsigned NS = DIST_BITS + 4;
  logic signed [CoefBits-1:0] cx_q, cy_q, cz_q;
  logic signed [OffsBits-1:0] cd_q;
  logic en;
  logic [NS:0] v_q;
  logic [MB-1:0] num;
  logic [NormBits-1:0] norm;
  logic [MB-HB-1:0] mh;
  logic [HB-1:0] ml;
  logic [2*(MB-HB)-1:0] hh_q;
  logic [MB-1:0] hl_q;
  logic [2*HB-1:0] ll_q;
  logic [NormBits-1:0] s3_q, s4_q;
  logic dgn3_q, dgn4_q;
  logic [RW-1:0] r4_q;
  logic [RW-1:0] rr [DIST_BITS+2];
  logic [TW-1:0] tt [DIST_BITS+2];
  logic [NormBits-1:0] ss [DIST_BITS+2];
  logic [DIST_BITS:0] qq [DIST_BITS+2];
  logic dd [DIST_BITS+2];
  logic sat;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0; cd_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegCoefX:   cx_q <= cfg_wdata_i[CoefBits-1:0];
        RegCoefY:   cy_q <= cfg_wdata_i[CoefBits-1:0];
        RegCoefZ:   cz_q <= cfg_wdata_i[CoefBits-1:0];
        RegCoefOff: cd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:0], s_axis_tvalid};
    end
  end

  p2pd_front #(.CoordBits(COORD_BITS), .MagBits(MB)) u_front (
    .clk_i, .en_i(en), .coef_x_i(cx_q), .coef_y_i(cy_q), .coef_z_i(cz_q),
    .coef_off_i(cd_q),
    .px_i(s_axis_tdata[COORD_BITS-1:0]),
    .py_i(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pz_i(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .num_o(num), .norm_o(norm)
  );

  // The numerator is squared from two halves over two stages.
  assign mh = num[MB-1:HB];
  assign ml = num[HB-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q <= mh * mh;
      hl_q <= mh * ml;
      ll_q <= ml * ml;
      s3_q <= norm;
      dgn3_q <= (norm == '0);
      r4_q <= (RW'(hh_q) << (2 * HB)) + (RW'(hl_q) << (HB + 1)) + RW'(ll_q);
      s4_q <= s3_q;
      dgn4_q <= dgn3_q;
    end
  end

  assign rr[0] = r4_q;
  assign tt[0] = '0;
  assign ss[0] = s4_q;
  assign qq[0] = '0;
  assign dd[0] = dgn4_q;

  for (genvar g = 0; g <= DIST_BITS; g++) begin : g_cell
    p2pd_cell #(
      .DistBits(DIST_BITS), .ResBits(RW), .AccBits(TW), .BitPos(DIST_BITS-g)
    ) u_cell (
      .clk_i, .en_i(en), .r_i(rr[g]), .t_i(tt[g]), .s_i(ss[g]), .q_i(qq[g]),
      .dgn_i(dd[g]), .r_o(rr[g+1]), .t_o(tt[g+1]), .s_o(ss[g+1]), .q_o(qq[g+1]),
      .dgn_o(dd[g+1])
    );
  end

  assign sat = qq[DIST_BITS+1][DIST_BITS] && !dd[DIST_BITS+1];

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[DIST_BITS-1:0] = dd[DIST_BITS+1] ? '0 :
      sat ? '1 : qq[DIST_BITS+1][DIST_BITS-1:0];
    m_axis_tdata[DIST_BITS] = sat;
    m_axis_tdata[DIST_BITS+1] = dd[DIST_BITS+1];
  end

  `P2P_ASSERT(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
  `P2P_ASSERT_NEVER(a_both, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[DIST_BITS] && m_axis_tdata[DIST_BITS+1], "both flags")
  `P2P_ASSERT(a_rdy, clk_i, rst_ni,
    !m_axis_tvalid |-> s_axis_tready, "not ready while empty")
endmodule
